>>> hw/rtl/rssa_pkg.sv
// shared types, constants and helpers of the ride session statistics block
// used by the channel interfaces, the serial divider and the top level
package rssa_pkg;

    localparam int unsigned GRACE_W  = 20;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ADDR_W   = 3;
    localparam int unsigned DIV_N_W  = 48;
    localparam int unsigned DIV_D_W  = 32;
    localparam int unsigned STEP_W   = $clog2(DIV_N_W + 1);

    localparam logic [GRACE_W-1:0] GRACE_RESET = GRACE_W'(10000);

    // word index of the grace register on the config port
    localparam logic [ADDR_W-3:0] REG_GRACE = '0;

    // quotient bits produced per division
    localparam logic [STEP_W-1:0] STEPS_SPEED = STEP_W'(48);
    localparam logic [STEP_W-1:0] STEPS_SMALL = STEP_W'(40);

    localparam logic [7:0] ZONE2_BPM = 8'd105;
    localparam logic [7:0] ZONE3_BPM = 8'd125;
    localparam logic [7:0] ZONE4_BPM = 8'd145;
    localparam logic [7:0] ZONE5_BPM = 8'd165;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_RUN   = 2'd1,
        MODE_PAUSE = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_TOGGLE = 2'd1,
        KIND_STOP   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ST_READY,
        ST_PROD,
        ST_APPLY,
        ST_SCHED,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        JOB_SPEED = 2'd0,
        JOB_CAD   = 2'd1,
        JOB_HEART = 2'd2
    } t_job;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] dt_ms;
        logic        fix_valid;
        logic [15:0] speed;
        logic        cadence_present;
        logic [7:0]  cadence_rpm;
        logic        has_heart_rate;
        logic [7:0]  heart_bpm;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  run_mode;
        logic        summary_valid;
        logic [31:0] moving_ms;
        logic [47:0] distance_raw;
        logic [15:0] live_speed;
        logic [15:0] avg_speed;
        logic [15:0] peak_speed;
        logic [7:0]  live_cadence;
        logic [7:0]  live_heart;
        logic [7:0]  mean_cadence;
        logic [7:0]  avg_heart;
        logic [2:0]  heart_zone;
    } t_out_item;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    function automatic logic [2:0] zone_of(input logic [7:0] bpm);
        logic [2:0] z;
        if (bpm < ZONE2_BPM) begin
            z = 3'd1;
        end else if (bpm < ZONE3_BPM) begin
            z = 3'd2;
        end else if (bpm < ZONE4_BPM) begin
            z = 3'd3;
        end else if (bpm < ZONE5_BPM) begin
            z = 3'd4;
        end else begin
            z = 3'd5;
        end
        return z;
    endfunction

endpackage

>>> hw/rtl/rssa_if.sv
// valid/ready channel interfaces for sensor items and statistics results
// payload types come from rssa_pkg
interface rssa_in_if;
    logic               valid;
    logic               ready;
    rssa_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface rssa_out_if;
    logic                valid;
    logic                ready;
    rssa_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/ride_session_stats_accumulator.sv
// Ride session statistics: one result per item on the o_res channel, one item in work at a
// time. Each item is taken in, its distance product formed, the statistics updated and the
// result loaded, and only then is the next item taken. A tick with a fix also refreshes
// the averages through the single serial divider (one quotient bit per cycle): a 48 bit
// speed division, then a 40 bit division for each cadence or heart rate that the tick
// carries. A result that waits on o_res holds the next item in its done state, and with it
// the block, until the waiting result is taken. Depends on rssa_pkg, rssa_in_if/rssa_out_if
// and rssa_div.
module ride_session_stats_accumulator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    rssa_in_if.sink                       i_item,
    rssa_out_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rssa_pkg::ADDR_W-1:0]   paddr,
    input  logic [rssa_pkg::DATA_W-1:0]   pwdata,
    output logic [rssa_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    rssa_pkg::t_state   r_state, n_state;
    rssa_pkg::t_mode    r_mode, n_mode;
    rssa_pkg::t_job     r_job, w_job;
    rssa_pkg::t_in_item r_item;
    rssa_pkg::t_out_item r_res, w_snap;
    logic               r_res_vld;

    logic [rssa_pkg::GRACE_W-1:0] r_grace;
    logic [31:0] r_prod;

    logic [31:0] r_since, n_since;
    logic [31:0] r_moving, n_moving;
    logic [47:0] r_dist, n_dist;
    logic [47:0] r_ssum, n_ssum;
    logic [15:0] r_smax, n_smax;
    logic [31:0] r_scnt, n_scnt;
    logic [39:0] r_csum, n_csum;
    logic [31:0] r_ccnt, n_ccnt;
    logic [39:0] r_hsum, n_hsum;
    logic [31:0] r_hcnt, n_hcnt;
    logic [15:0] r_last_speed, n_last_speed;
    logic [7:0]  r_last_cad, n_last_cad;
    logic [7:0]  r_last_heart, n_last_heart;
    logic [15:0] r_avg_speed, n_avg_speed;
    logic [7:0]  r_avg_cad, n_avg_cad;
    logic [7:0]  r_avg_heart, n_avg_heart;
    logic        r_summary, n_summary;
    logic [2:0]  r_pend, n_pend;

    logic        w_accept;
    logic        w_load;
    logic        w_cfg_wr;

    rssa_pkg::t_div_req w_div_req;
    rssa_pkg::t_div_sts w_div_sts;
    logic [rssa_pkg::DIV_N_W-1:0] w_dividend;
    logic [rssa_pkg::DIV_D_W-1:0] w_divisor;
    logic [rssa_pkg::DIV_N_W-1:0] w_quot;

    // saturating sums
    logic [32:0] w_since_sum, w_mov_sum, w_scnt_sum, w_ccnt_sum, w_hcnt_sum;
    logic [48:0] w_dist_sum, w_ssum_sum;
    logic [40:0] w_csum_sum, w_hsum_sum;
    logic [31:0] w_since_sat, w_mov_sat, w_scnt_sat, w_ccnt_sat, w_hcnt_sat;
    logic [47:0] w_dist_sat, w_ssum_sat;
    logic [39:0] w_csum_sat, w_hsum_sat;

    // config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready &
                      (paddr[rssa_pkg::ADDR_W-1:2] == rssa_pkg::REG_GRACE);
    assign prdata   = (paddr[rssa_pkg::ADDR_W-1:2] == rssa_pkg::REG_GRACE) ?
                      {{(rssa_pkg::DATA_W-rssa_pkg::GRACE_W){1'b0}}, r_grace} : '0;

    always_comb begin
        w_since_sum = {1'b0, r_since} + {17'b0, r_item.dt_ms};
        w_mov_sum   = {1'b0, r_moving} + {17'b0, r_item.dt_ms};
        w_dist_sum  = {1'b0, r_dist} + {17'b0, r_prod};
        w_ssum_sum  = {1'b0, r_ssum} + {33'b0, r_item.speed};
        w_scnt_sum  = {1'b0, r_scnt} + 33'd1;
        w_csum_sum  = {1'b0, r_csum} + {33'b0, r_item.cadence_rpm};
        w_ccnt_sum  = {1'b0, r_ccnt} + 33'd1;
        w_hsum_sum  = {1'b0, r_hsum} + {33'b0, r_item.heart_bpm};
        w_hcnt_sum  = {1'b0, r_hcnt} + 33'd1;
        w_since_sat = w_since_sum[32] ? '1 : w_since_sum[31:0];
        w_mov_sat   = w_mov_sum[32] ? '1 : w_mov_sum[31:0];
        w_dist_sat  = w_dist_sum[48] ? '1 : w_dist_sum[47:0];
        w_ssum_sat  = w_ssum_sum[48] ? '1 : w_ssum_sum[47:0];
        w_scnt_sat  = w_scnt_sum[32] ? '1 : w_scnt_sum[31:0];
        w_csum_sat  = w_csum_sum[40] ? '1 : w_csum_sum[39:0];
        w_ccnt_sat  = w_ccnt_sum[32] ? '1 : w_ccnt_sum[31:0];
        w_hsum_sat  = w_hsum_sum[40] ? '1 : w_hsum_sum[39:0];
        w_hcnt_sat  = w_hcnt_sum[32] ? '1 : w_hcnt_sum[31:0];
    end

    // lowest pending division goes first
    always_comb begin
        if (r_pend[0]) begin
            w_job = rssa_pkg::JOB_SPEED;
        end else if (r_pend[1]) begin
            w_job = rssa_pkg::JOB_CAD;
        end else begin
            w_job = rssa_pkg::JOB_HEART;
        end
    end

    always_comb begin
        case (w_job)
            rssa_pkg::JOB_SPEED: begin
                w_dividend = r_ssum;
                w_divisor  = r_scnt;
            end
            rssa_pkg::JOB_CAD: begin
                w_dividend = {r_csum, 8'b0};
                w_divisor  = r_ccnt;
            end
            default: begin
                w_dividend = {r_hsum, 8'b0};
                w_divisor  = r_hcnt;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rssa_pkg::ST_READY: begin
                if (i_item.valid) begin
                    n_state = rssa_pkg::ST_PROD;
                end
            end
            rssa_pkg::ST_PROD:  n_state = rssa_pkg::ST_APPLY;
            rssa_pkg::ST_APPLY: n_state = rssa_pkg::ST_SCHED;
            rssa_pkg::ST_SCHED: begin
                n_state = (r_pend != 3'b000) ? rssa_pkg::ST_DIV : rssa_pkg::ST_DONE;
            end
            rssa_pkg::ST_DIV: begin
                if (w_div_sts.done) begin
                    n_state = rssa_pkg::ST_SCHED;
                end
            end
            rssa_pkg::ST_DONE: begin
                if (!r_res_vld || o_res.ready) begin
                    n_state = rssa_pkg::ST_READY;
                end
            end
            default: n_state = rssa_pkg::ST_READY;
        endcase
    end

    // sequencer outputs
    always_comb begin
        w_accept        = 1'b0;
        w_load          = 1'b0;
        w_div_req.start = 1'b0;
        w_div_req.steps = (w_job == rssa_pkg::JOB_SPEED) ? rssa_pkg::STEPS_SPEED
                                                         : rssa_pkg::STEPS_SMALL;
        case (r_state)
            rssa_pkg::ST_READY: w_accept = i_item.valid;
            rssa_pkg::ST_SCHED: w_div_req.start = (r_pend != 3'b000);
            rssa_pkg::ST_DONE:  w_load = !r_res_vld || o_res.ready;
            default: ;
        endcase
    end

    // no transfer is taken while reset is held
    assign i_item.ready = (r_state == rssa_pkg::ST_READY) && i_rst_n;

    // statistics update
    always_comb begin
        n_mode       = r_mode;
        n_since      = r_since;
        n_moving     = r_moving;
        n_dist       = r_dist;
        n_ssum       = r_ssum;
        n_smax       = r_smax;
        n_scnt       = r_scnt;
        n_csum       = r_csum;
        n_ccnt       = r_ccnt;
        n_hsum       = r_hsum;
        n_hcnt       = r_hcnt;
        n_last_speed = r_last_speed;
        n_last_cad   = r_last_cad;
        n_last_heart = r_last_heart;
        n_avg_speed  = r_avg_speed;
        n_avg_cad    = r_avg_cad;
        n_avg_heart  = r_avg_heart;
        n_summary    = r_summary;
        n_pend       = r_pend;

        if (r_state == rssa_pkg::ST_APPLY) begin
            n_summary = 1'b0;
            case (r_item.kind)
                rssa_pkg::KIND_TICK: begin
                    if (r_mode == rssa_pkg::MODE_RUN) begin
                        if (!r_item.fix_valid) begin
                            n_since = w_since_sat;
                            if (w_since_sat <= {12'b0, r_grace}) begin
                                n_moving = w_mov_sat;
                            end
                        end else begin
                            n_since      = '0;
                            n_moving     = w_mov_sat;
                            n_last_speed = r_item.speed;
                            n_dist       = w_dist_sat;
                            n_ssum       = w_ssum_sat;
                            n_scnt       = w_scnt_sat;
                            if (r_item.speed > r_smax) begin
                                n_smax = r_item.speed;
                            end
                            if (r_item.cadence_present) begin
                                n_last_cad = r_item.cadence_rpm;
                                n_csum     = w_csum_sat;
                                n_ccnt     = w_ccnt_sat;
                            end
                            if (r_item.has_heart_rate) begin
                                n_last_heart = r_item.heart_bpm;
                                n_hsum       = w_hsum_sat;
                                n_hcnt       = w_hcnt_sat;
                            end
                            n_pend = {r_item.has_heart_rate, r_item.cadence_present, 1'b1};
                        end
                    end
                end
                rssa_pkg::KIND_TOGGLE: begin
                    case (r_mode)
                        rssa_pkg::MODE_IDLE: begin
                            n_mode       = rssa_pkg::MODE_RUN;
                            n_since      = '0;
                            n_moving     = '0;
                            n_dist       = '0;
                            n_ssum       = '0;
                            n_smax       = '0;
                            n_scnt       = '0;
                            n_csum       = '0;
                            n_ccnt       = '0;
                            n_hsum       = '0;
                            n_hcnt       = '0;
                            n_last_speed = '0;
                            n_last_cad   = '0;
                            n_last_heart = '0;
                            n_avg_speed  = '0;
                            n_avg_cad    = '0;
                            n_avg_heart  = '0;
                        end
                        rssa_pkg::MODE_RUN:   n_mode = rssa_pkg::MODE_PAUSE;
                        rssa_pkg::MODE_PAUSE: n_mode = rssa_pkg::MODE_RUN;
                        default: ;
                    endcase
                end
                rssa_pkg::KIND_STOP: begin
                    n_summary = (r_mode != rssa_pkg::MODE_IDLE) && (r_scnt != '0);
                    n_mode    = rssa_pkg::MODE_IDLE;
                end
                default: ;
            endcase
        end

        if (r_state == rssa_pkg::ST_DIV && w_div_sts.done) begin
            case (r_job)
                rssa_pkg::JOB_SPEED: begin
                    n_avg_speed = w_quot[15:0];
                    n_pend[0]   = 1'b0;
                end
                rssa_pkg::JOB_CAD: begin
                    n_avg_cad = w_quot[7:0];
                    n_pend[1] = 1'b0;
                end
                default: begin
                    n_avg_heart = w_quot[7:0];
                    n_pend[2]   = 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        w_snap.run_mode      = r_mode;
        w_snap.summary_valid = r_summary;
        w_snap.moving_ms     = r_moving;
        w_snap.distance_raw  = r_dist;
        w_snap.live_speed    = r_last_speed;
        w_snap.avg_speed     = r_avg_speed;
        w_snap.peak_speed    = r_smax;
        w_snap.live_cadence  = r_last_cad;
        w_snap.live_heart    = r_last_heart;
        w_snap.mean_cadence  = r_avg_cad;
        w_snap.avg_heart     = r_avg_heart;
        w_snap.heart_zone    = rssa_pkg::zone_of(r_last_heart);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= rssa_pkg::ST_READY;
            r_mode       <= rssa_pkg::MODE_IDLE;
            r_job        <= rssa_pkg::JOB_SPEED;
            r_res_vld    <= 1'b0;
            r_grace      <= rssa_pkg::GRACE_RESET;
            r_since      <= '0;
            r_moving     <= '0;
            r_dist       <= '0;
            r_ssum       <= '0;
            r_smax       <= '0;
            r_scnt       <= '0;
            r_csum       <= '0;
            r_ccnt       <= '0;
            r_hsum       <= '0;
            r_hcnt       <= '0;
            r_last_speed <= '0;
            r_last_cad   <= '0;
            r_last_heart <= '0;
            r_avg_speed  <= '0;
            r_avg_cad    <= '0;
            r_avg_heart  <= '0;
            r_summary    <= 1'b0;
            r_pend       <= '0;
        end else begin
            r_state      <= n_state;
            r_mode       <= n_mode;
            r_since      <= n_since;
            r_moving     <= n_moving;
            r_dist       <= n_dist;
            r_ssum       <= n_ssum;
            r_smax       <= n_smax;
            r_scnt       <= n_scnt;
            r_csum       <= n_csum;
            r_ccnt       <= n_ccnt;
            r_hsum       <= n_hsum;
            r_hcnt       <= n_hcnt;
            r_last_speed <= n_last_speed;
            r_last_cad   <= n_last_cad;
            r_last_heart <= n_last_heart;
            r_avg_speed  <= n_avg_speed;
            r_avg_cad    <= n_avg_cad;
            r_avg_heart  <= n_avg_heart;
            r_summary    <= n_summary;
            r_pend       <= n_pend;
            if (w_div_req.start) begin
                r_job <= w_job;
            end
            if (w_cfg_wr) begin
                r_grace <= pwdata[rssa_pkg::GRACE_W-1:0];
            end
            if (w_load) begin
                r_res_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_res_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item.payload;
        end
        if (r_state == rssa_pkg::ST_PROD) begin
            r_prod <= r_item.speed * r_item.dt_ms;
        end
        if (w_load) begin
            r_res <= w_snap;
        end
    end

    assign o_res.valid   = r_res_vld;
    assign o_res.payload = r_res;

    rssa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_sts      (w_div_sts),
        .o_quot     (w_quot)
    );

`ifndef SYNTH
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_req.start |-> !w_div_sts.busy)
        else $error("divider restarted while busy");

    a_div_done_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rssa_pkg::ST_DIV && w_div_sts.done) |-> (r_pend != 3'b000))
        else $error("division finished with nothing pending");

    a_accept_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (!w_div_sts.busy && r_pend == 3'b000))
        else $error("new transfer taken while averages still in work");

    a_live_below_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_last_speed <= r_smax)
        else $error("live speed above peak speed");

    a_summary_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res_vld && r_res.summary_valid) |-> (r_res.run_mode == rssa_pkg::MODE_IDLE))
        else $error("summary flagged outside idle");
`endif

endmodule

>>> hw/rtl/rssa_div.sv
// restoring serial divider, one quotient bit per cycle
// request and status structs come from rssa_pkg
module rssa_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rssa_pkg::t_div_req               i_req,
    input  logic [rssa_pkg::DIV_N_W-1:0]     i_dividend,
    input  logic [rssa_pkg::DIV_D_W-1:0]     i_divisor,
    output rssa_pkg::t_div_sts               o_sts,
    output logic [rssa_pkg::DIV_N_W-1:0]     o_quot
);

    logic                            r_busy;
    logic                            r_done;
    logic [rssa_pkg::STEP_W-1:0]     r_cnt;
    logic [rssa_pkg::DIV_D_W-1:0]    r_rem;
    logic [rssa_pkg::DIV_N_W-1:0]    r_quo;
    logic [rssa_pkg::DIV_D_W-1:0]    r_div;

    logic [rssa_pkg::DIV_D_W:0]      w_shift;
    logic [rssa_pkg::DIV_D_W+1:0]    w_diff;
    logic                            w_ge;
    logic [rssa_pkg::DIV_D_W-1:0]    n_rem;
    logic [rssa_pkg::DIV_N_W-1:0]    n_quo;

    always_comb begin
        w_shift = {r_rem, r_quo[rssa_pkg::DIV_N_W-1]};
        w_diff  = {1'b0, w_shift} - {2'b00, r_div};
        w_ge    = ~w_diff[rssa_pkg::DIV_D_W+1];
        // remainder stays below the divisor, so its top bit is always clear
        n_rem   = w_ge ? w_diff[rssa_pkg::DIV_D_W-1:0] : w_shift[rssa_pkg::DIV_D_W-1:0];
        n_quo   = {r_quo[rssa_pkg::DIV_N_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == rssa_pkg::STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quo;

endmodule

>>> tb/tb_ride_session_stats_accumulator.sv
// self-checking testbench for ride_session_stats_accumulator: directed and random
// sensor sequences, an in-bench model of the session statistics, apb grace writes
// depends on rssa_pkg, rssa_in_if/rssa_out_if and the top-level rtl
`timescale 1ns / 1ps

module tb_ride_session_stats_accumulator;

    localparam longint unsigned LIM32 = 64'hFFFF_FFFF;
    localparam longint unsigned LIM40 = 64'hFF_FFFF_FFFF;
    localparam longint unsigned LIM48 = 64'hFFFF_FFFF_FFFF;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [rssa_pkg::ADDR_W-1:0] paddr;
    logic [rssa_pkg::DATA_W-1:0] pwdata;
    logic [rssa_pkg::DATA_W-1:0] prdata;
    logic                        pready;

    rssa_in_if  item_ch ();
    rssa_out_if res_ch ();

    ride_session_stats_accumulator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // session model state
    logic [rssa_pkg::GRACE_W-1:0] grace_ms;
    rssa_pkg::t_mode mode_q;
    logic [31:0] since_fix;
    logic [31:0] moving_t;
    logic [47:0] dist_acc;
    logic [47:0] spd_sum;
    logic [15:0] spd_max;
    logic [31:0] spd_cnt;
    logic [39:0] cad_sum;
    logic [31:0] cad_cnt;
    logic [39:0] hr_sum;
    logic [31:0] hr_cnt;
    logic [15:0] last_spd;
    logic [7:0]  last_cad;
    logic [7:0]  last_hr;

    rssa_pkg::t_in_item  pending_items[$];
    rssa_pkg::t_out_item expected_stats[$];

    int queued_total = 0;
    int results_seen = 0;
    int mismatches   = 0;
    int send_gap;
    int stall_left;
    int hold_left;
    bit steady_flow  = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #100_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic longint unsigned sat_sum(input longint unsigned a, input longint unsigned b,
                                                input longint unsigned lim);
        return (a + b > lim) ? lim : a + b;
    endfunction

    function automatic int draw_gap();
        return steady_flow ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic rssa_pkg::t_out_item ride_stats_after(input rssa_pkg::t_in_item it);
        rssa_pkg::t_out_item r;
        logic                summary;
        summary = 1'b0;
        case (it.kind)
            rssa_pkg::KIND_TICK: begin
                if (mode_q == rssa_pkg::MODE_RUN) begin
                    if (!it.fix_valid) begin
                        since_fix = 32'(sat_sum(since_fix, it.dt_ms, LIM32));
                        if (since_fix <= grace_ms) begin
                            moving_t = 32'(sat_sum(moving_t, it.dt_ms, LIM32));
                        end
                    end else begin
                        since_fix = '0;
                        moving_t  = 32'(sat_sum(moving_t, it.dt_ms, LIM32));
                        last_spd  = it.speed;
                        dist_acc  = 48'(sat_sum(dist_acc, it.speed * 64'(it.dt_ms), LIM48));
                        spd_sum   = 48'(sat_sum(spd_sum, it.speed, LIM48));
                        if (it.speed > spd_max) begin
                            spd_max = it.speed;
                        end
                        spd_cnt = 32'(sat_sum(spd_cnt, 1, LIM32));
                        if (it.cadence_present) begin
                            last_cad = it.cadence_rpm;
                            cad_sum  = 40'(sat_sum(cad_sum, it.cadence_rpm, LIM40));
                            cad_cnt  = 32'(sat_sum(cad_cnt, 1, LIM32));
                        end
                        if (it.has_heart_rate) begin
                            last_hr = it.heart_bpm;
                            hr_sum  = 40'(sat_sum(hr_sum, it.heart_bpm, LIM40));
                            hr_cnt  = 32'(sat_sum(hr_cnt, 1, LIM32));
                        end
                    end
                end
            end
            rssa_pkg::KIND_TOGGLE: begin
                if (mode_q == rssa_pkg::MODE_IDLE) begin
                    {since_fix, moving_t, dist_acc, spd_sum, spd_max, spd_cnt} = '0;
                    {cad_sum, cad_cnt, hr_sum, hr_cnt, last_spd, last_cad, last_hr} = '0;
                    mode_q = rssa_pkg::MODE_RUN;
                end else if (mode_q == rssa_pkg::MODE_RUN) begin
                    mode_q = rssa_pkg::MODE_PAUSE;
                end else begin
                    mode_q = rssa_pkg::MODE_RUN;
                end
            end
            rssa_pkg::KIND_STOP: begin
                summary = (mode_q != rssa_pkg::MODE_IDLE) && (spd_cnt != 0);
                mode_q  = rssa_pkg::MODE_IDLE;
            end
            default: ;
        endcase
        r.run_mode      = mode_q;
        r.summary_valid = summary;
        r.moving_ms     = moving_t;
        r.distance_raw  = dist_acc;
        r.live_speed    = last_spd;
        r.avg_speed     = (spd_cnt != 0) ? 16'(spd_sum / spd_cnt) : '0;
        r.peak_speed    = spd_max;
        r.live_cadence  = last_cad;
        r.live_heart    = last_hr;
        r.mean_cadence  = (cad_cnt != 0) ? 8'(cad_sum / cad_cnt) : '0;
        r.avg_heart     = (hr_cnt != 0) ? 8'(hr_sum / hr_cnt) : '0;
        // zone climbs by one per threshold reached
        r.heart_zone    = 3'd1 + 3'(last_hr >= rssa_pkg::ZONE2_BPM)
                        + 3'(last_hr >= rssa_pkg::ZONE3_BPM)
                        + 3'(last_hr >= rssa_pkg::ZONE4_BPM)
                        + 3'(last_hr >= rssa_pkg::ZONE5_BPM);
        return r;
    endfunction

    function automatic rssa_pkg::t_in_item ctrl_item(input logic [1:0] k);
        rssa_pkg::t_in_item r;
        logic [63:0]        raw;
        raw    = {$urandom(), $urandom()};
        r      = raw[$bits(rssa_pkg::t_in_item)-1:0];
        r.kind = k;
        return r;
    endfunction

    function automatic rssa_pkg::t_in_item tick_item(input logic fix, input logic [15:0] dt,
                                                     input logic [15:0] spd, input logic hc,
                                                     input logic [7:0] cad, input logic hh,
                                                     input logic [7:0] hr);
        rssa_pkg::t_in_item r;
        r = ctrl_item(rssa_pkg::KIND_TICK);
        r.fix_valid       = fix;
        r.dt_ms           = dt;
        r.speed           = spd;
        r.cadence_present = hc;
        r.cadence_rpm     = cad;
        r.has_heart_rate  = hh;
        r.heart_bpm       = hr;
        return r;
    endfunction

    function automatic rssa_pkg::t_in_item rand_tick(input logic fix);
        rssa_pkg::t_in_item r;
        r = ctrl_item(rssa_pkg::KIND_TICK);
        r.fix_valid = fix;
        // short intervals keep the no-fix grace window in play
        if ($urandom_range(0, 3) != 0) begin
            r.dt_ms = 16'($urandom_range(0, 3000));
        end
        if ($urandom_range(0, 2) == 0) begin
            r.speed = 16'($urandom_range(0, 6000));
        end
        if ($urandom_range(0, 1) == 0) begin
            r.heart_bpm = 8'($urandom_range(90, 180));
        end
        return r;
    endfunction

    task automatic enqueue(input rssa_pkg::t_in_item it);
        pending_items.push_back(it);
        queued_total++;
    endtask

    task automatic queue_rides(input int n);
        int added;
        int len;
        int p;
        added = 0;
        while (added < n) begin
            if ($urandom_range(0, 9) == 0) begin
                enqueue(ctrl_item(2'($urandom_range(0, 3))));
                added++;
            end else begin
                enqueue(ctrl_item(rssa_pkg::KIND_TOGGLE));
                len = $urandom_range(1, 25);
                repeat (len) begin
                    p = $urandom_range(0, 19);
                    if (p == 0) begin
                        // pause, an ignored tick, resume
                        enqueue(ctrl_item(rssa_pkg::KIND_TOGGLE));
                        enqueue(rand_tick(1'($urandom_range(0, 1))));
                        enqueue(ctrl_item(rssa_pkg::KIND_TOGGLE));
                    end else begin
                        enqueue(rand_tick(p >= 6));
                    end
                end
                // now and then the ride is left open
                if ($urandom_range(0, 7) != 0) begin
                    enqueue(ctrl_item(rssa_pkg::KIND_STOP));
                end
                added += len + 2;
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge i_clk);
        while (results_seen < queued_total);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic program_grace(input logic [rssa_pkg::GRACE_W-1:0] v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {rssa_pkg::REG_GRACE, 2'b00};
        pwdata  <= rssa_pkg::DATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        grace_ms = v;
        // psel stays high: this is the setup cycle of the read back
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata[rssa_pkg::GRACE_W-1:0] !== v) begin
            $error("no_fix_grace_ms: expected %0d, got %0d", v,
                   prdata[rssa_pkg::GRACE_W-1:0]);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic cmp_field(input string name, input logic [63:0] e, input logic [63:0] g);
        if (e !== g) begin
            $error("%s: expected %0d, got %0d", name, e, g);
            mismatches++;
        end
    endtask

    task automatic check_stats(input rssa_pkg::t_out_item got);
        rssa_pkg::t_out_item e;
        if (expected_stats.size() == 0) begin
            $error("result transfer with no expectation pending");
            mismatches++;
        end else begin
            e = expected_stats.pop_front();
            cmp_field("run_mode", e.run_mode, got.run_mode);
            cmp_field("summary_valid", e.summary_valid, got.summary_valid);
            cmp_field("moving_ms", e.moving_ms, got.moving_ms);
            cmp_field("distance_raw", e.distance_raw, got.distance_raw);
            cmp_field("live_speed", e.live_speed, got.live_speed);
            cmp_field("avg_speed", e.avg_speed, got.avg_speed);
            cmp_field("peak_speed", e.peak_speed, got.peak_speed);
            cmp_field("live_cadence", e.live_cadence, got.live_cadence);
            cmp_field("live_heart", e.live_heart, got.live_heart);
            cmp_field("mean_cadence", e.mean_cadence, got.mean_cadence);
            cmp_field("avg_heart", e.avg_heart, got.avg_heart);
            cmp_field("heart_zone", e.heart_zone, got.heart_zone);
        end
    endtask

    // item driver: one transfer per accepted item, random gap after each (none in steady flow)
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_ch.valid   <= 1'b0;
            item_ch.payload <= '0;
            send_gap = 0;
        end else begin
            if (item_ch.valid && item_ch.ready) begin
                expected_stats.push_back(ride_stats_after(item_ch.payload));
            end
            if (!item_ch.valid || item_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    item_ch.valid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    item_ch.payload <= pending_items.pop_front();
                    item_ch.valid   <= 1'b1;
                    send_gap = draw_gap();
                end else begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: random stalls while a result waits (none in steady flow), two long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (hold_left > 0) begin
                hold_left--;
            end
            if (res_ch.valid && res_ch.ready) begin
                check_stats(res_ch.payload);
                results_seen++;
                stall_left = draw_gap();
                if (results_seen == 60 || results_seen == 700) begin
                    hold_left = 400;
                end
            end else if (res_ch.valid && stall_left > 0) begin
                stall_left--;
            end
            res_ch.ready <= (hold_left == 0) && (stall_left == 0);
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        grace_ms        = rssa_pkg::GRACE_RESET;
        mode_q          = rssa_pkg::MODE_IDLE;
        {since_fix, moving_t, dist_acc, spd_sum, spd_max, spd_cnt} = '0;
        {cad_sum, cad_cnt, hr_sum, hr_cnt, last_spd, last_cad, last_hr} = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on the reset grace window
        enqueue(tick_item(1'b1, 16'd500, 16'd900, 1'b1, 8'd80, 1'b1, 8'd120)); // ignored in idle
        enqueue(ctrl_item(2'd3));
        enqueue(ctrl_item(rssa_pkg::KIND_STOP));
        enqueue(ctrl_item(rssa_pkg::KIND_TOGGLE));
        enqueue(ctrl_item(rssa_pkg::KIND_STOP));                        // ride without samples
        enqueue(ctrl_item(rssa_pkg::KIND_TOGGLE));
        enqueue(tick_item(1'b1, 16'd0, 16'd0, 1'b1, 8'd0, 1'b1, 8'd0));
        enqueue(tick_item(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 8'hFF, 1'b1, 8'hFF));
        enqueue(tick_item(1'b1, 16'd1000, 16'd1, 1'b1, 8'd1, 1'b1, 8'd104));
        enqueue(tick_item(1'b1, 16'd1000, 16'd2000, 1'b0, 8'd90, 1'b1, 8'd105));
        enqueue(tick_item(1'b1, 16'd1000, 16'd2500, 1'b1, 8'd95, 1'b1, 8'd125));
        enqueue(tick_item(1'b1, 16'd1000, 16'd3000, 1'b1, 8'd92, 1'b1, 8'd145));
        enqueue(tick_item(1'b1, 16'd1000, 16'd2800, 1'b0, 8'd0, 1'b1, 8'd164));
        enqueue(tick_item(1'b1, 16'd1000, 16'd2700, 1'b1, 8'd88, 1'b1, 8'd165));
        // no-fix ticks up to the edge of the grace window and one past it
        enqueue(tick_item(1'b0, 16'd5000, 16'd4000, 1'b1, 8'd70, 1'b1, 8'd70));
        enqueue(tick_item(1'b0, 16'd5000, 16'd4000, 1'b1, 8'd70, 1'b1, 8'd70));
        enqueue(tick_item(1'b0, 16'd1, 16'd4000, 1'b1, 8'd70, 1'b1, 8'd70));
        enqueue(tick_item(1'b1, 16'd1000, 16'd2600, 1'b0, 8'd0, 1'b0, 8'd0));
        enqueue(ctrl_item(2'd3));
        enqueue(ctrl_item(rssa_pkg::KIND_TOGGLE));
        enqueue(tick_item(1'b1, 16'd1000, 16'd5000, 1'b1, 8'd99, 1'b1, 8'd99)); // paused
        enqueue(ctrl_item(rssa_pkg::KIND_TOGGLE));
        enqueue(ctrl_item(rssa_pkg::KIND_STOP));
        enqueue(tick_item(1'b1, 16'd1000, 16'd5000, 1'b1, 8'd99, 1'b1, 8'd99)); // after stop
        enqueue(ctrl_item(rssa_pkg::KIND_TOGGLE));
        wait_idle();

        program_grace('0);
        queue_rides(260);
        wait_idle();

        program_grace(rssa_pkg::GRACE_W'(600000));
        queue_rides(260);
        wait_idle();

        program_grace(rssa_pkg::GRACE_W'($urandom_range(1, 20000)));
        steady_flow = 1'b1;
        queue_rides(260);
        wait_idle();
        steady_flow = 1'b0;

        program_grace(rssa_pkg::GRACE_W'($urandom_range(1000, 60000)));
        queue_rides(260);
        wait_idle();

        program_grace(rssa_pkg::GRACE_W'(10000));
        queue_rides(260);
        wait_idle();

        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && expected_stats.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            if (expected_stats.size() != 0) begin
                $error("%0d expected results never arrived", expected_stats.size());
            end
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
